/* rtl/hcb_pkg.sv */
`timescale 1ns / 1ps

package hcb_pkg;

    localparam int MAX_BLOCK   = 3;
    localparam int LETTER_W    = 5;
    localparam int KEY_ROW_W   = MAX_BLOCK * LETTER_W;
    localparam int CNT_W       = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = KEY_ROW_W;
    localparam int CHAR_W      = 7;

    localparam int ALPHA       = 26;
    localparam logic [CHAR_W-1:0] LETTER_A = 7'd65;

    // widest dot product: MAX_BLOCK terms of 31 * 31
    localparam int SUM_W       = 12;
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP       = (1 << RECIP_SHIFT) / ALPHA + 1;
    localparam int PROD_W      = SUM_W + RECIP_SHIFT;
    localparam int Q_W         = 7;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BLOCK_SIZE = 2'd0,
        CFG_KEY_ROW0   = 2'd1,
        CFG_KEY_ROW1   = 2'd2,
        CFG_KEY_ROW2   = 2'd3
    } cfg_idx_t;

    typedef logic [MAX_BLOCK-1:0][KEY_ROW_W-1:0] key_t;

    typedef struct packed {
        logic [MAX_BLOCK-1:0][LETTER_W-1:0] letters;
        logic [CNT_W-1:0]                   count;
    } block_t;

endpackage

/* rtl/hcb_front.sv */
`timescale 1ns / 1ps

module hcb_front
    import hcb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [CNT_W-1:0]    size,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [LETTER_W-1:0] letter_index,
    input  logic                message_end,
    input  logic                full,
    output logic                push,
    output block_t              push_block
);

    logic [CNT_W-1:0]    fill_reg;
    logic [CNT_W-1:0]    fill_next;
    logic [LETTER_W-1:0] held_reg [MAX_BLOCK];
    logic [CNT_W-1:0]    n;
    logic                accept;
    logic                close;

    assign in_stall = full;
    assign accept   = in_valid && !full;
    assign n        = fill_reg + CNT_W'(1);
    assign close    = (n >= size) || message_end;
    assign push     = accept && close;

    always_comb
    begin
        push_block.count = n;
        for (int j = 0; j < MAX_BLOCK; j++)
        begin
            if (CNT_W'(j) < fill_reg)
                push_block.letters[j] = held_reg[j];
            else if (CNT_W'(j) == fill_reg)
                push_block.letters[j] = letter_index;
            else
                push_block.letters[j] = '0;
        end
    end

    always_comb
    begin
        fill_next = fill_reg;
        if (accept)
            fill_next = close ? '0 : n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fill_reg <= '0;
        else
            fill_reg <= fill_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            held_reg[fill_reg] <= letter_index;
    end

endmodule

/* rtl/hcb_queue.sv */
`timescale 1ns / 1ps

module hcb_queue
    import hcb_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  block_t push_block,
    output logic   full,
    input  logic   pop,
    output logic   head_valid,
    output block_t head
);

    localparam int DEPTH = 2;

    block_t     mem_reg [DEPTH];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full       = (count_reg == 2'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_block;
    end

endmodule

/* rtl/hcb_back.sv */
`timescale 1ns / 1ps

module hcb_back
    import hcb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  key_t              key,
    input  logic              head_valid,
    input  block_t            head,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [CHAR_W-1:0] cipher_char,
    output logic              last_of_run
);

    logic [CNT_W-1:0]     row_reg;
    logic [CNT_W-1:0]     row_next;
    logic                 last_row;
    logic                 issue;
    logic [KEY_ROW_W-1:0] krow;
    logic [SUM_W-1:0]     dot;

    logic                 s1_valid_reg;
    logic [SUM_W-1:0]     s1_sum_reg;
    logic                 s1_last_reg;
    logic                 s2_valid_reg;
    logic [SUM_W-1:0]     s2_sum_reg;
    logic [Q_W-1:0]       s2_q_reg;
    logic                 s2_last_reg;
    logic                 out_valid_reg;
    logic [CHAR_W-1:0]    out_char_reg;
    logic                 out_last_reg;

    logic                 out_adv;
    logic                 s2_adv;
    logic                 s1_adv;
    logic [PROD_W-1:0]    recip_prod;
    logic [SUM_W-1:0]     rem_full;

    assign out_adv  = !out_valid_reg || !out_stall;
    assign s2_adv   = !s2_valid_reg || out_adv;
    assign s1_adv   = !s1_valid_reg || s2_adv;

    assign last_row = (row_reg == head.count - CNT_W'(1));
    assign issue    = head_valid && s1_adv;
    assign pop      = issue && last_row;
    assign row_next = issue ? (last_row ? '0 : row_reg + CNT_W'(1)) : row_reg;

    assign krow = key[row_reg];

    always_comb
    begin
        dot = '0;
        for (int j = 0; j < MAX_BLOCK; j++)
            dot = dot + SUM_W'(krow[j*LETTER_W +: LETTER_W]) * SUM_W'(head.letters[j]);
    end

    // remainder by reciprocal: exact for every sum that can occur, up to MAX_BLOCK terms of 31 * 31
    assign recip_prod = PROD_W'(s1_sum_reg) * PROD_W'(RECIP);
    assign rem_full   = s2_sum_reg - SUM_W'(s2_q_reg) * SUM_W'(ALPHA);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            row_reg <= row_next;
            if (s1_adv)
                s1_valid_reg <= issue;
            if (s2_adv)
                s2_valid_reg <= s1_valid_reg;
            if (out_adv)
                out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s1_sum_reg  <= dot;
            s1_last_reg <= last_row;
        end
        if (s2_adv)
        begin
            s2_sum_reg  <= s1_sum_reg;
            s2_q_reg    <= recip_prod[RECIP_SHIFT +: Q_W];
            s2_last_reg <= s1_last_reg;
        end
        if (out_adv)
        begin
            out_char_reg <= LETTER_A + CHAR_W'(rem_full[LETTER_W-1:0]);
            out_last_reg <= s2_last_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign cipher_char = out_char_reg;
    assign last_of_run = out_last_reg;

endmodule

/* rtl/hill_cipher_block_encrypt.sv */
// Hill cipher encryption, mod 26, block of 2 or 3 letters.
// Throughput: one letter accepted and one cipher letter delivered per cycle while in_stall and out_stall are low.
// The closing letter of a block goes through the queue, then the dot product (s1),
// reciprocal quotient (s2) and remainder (output) registers; the cipher letters
// of a block follow one a cycle unless out_stall holds them.
// Reset (rst_n, async, active low) empties the open block, the queue and the pipeline,
// and sets block size 2 with an all-zero key.
`timescale 1ns / 1ps

module hill_cipher_block_encrypt
    import hcb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [LETTER_W-1:0]   letter_index,
    input  logic                  message_end,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [CHAR_W-1:0]     cipher_char,
    output logic                  last_of_run,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [CNT_W-1:0] block_size_reg;
    key_t             key_reg;
    logic [CNT_W-1:0] size;

    logic   push;
    block_t push_block;
    logic   full;
    logic   pop;
    logic   head_valid;
    block_t head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_size_reg <= CNT_W'(2);
            key_reg        <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_BLOCK_SIZE: block_size_reg <= cfg_data[CNT_W-1:0];
                CFG_KEY_ROW0:   key_reg[0]     <= cfg_data;
                CFG_KEY_ROW1:   key_reg[1]     <= cfg_data;
                CFG_KEY_ROW2:   key_reg[2]     <= cfg_data;
            endcase
        end
    end

    // sizes 0 and 1 act as 2
    assign size = (block_size_reg < CNT_W'(2)) ? CNT_W'(2) : block_size_reg;

    hcb_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .size         (size),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .letter_index (letter_index),
        .message_end  (message_end),
        .full         (full),
        .push         (push),
        .push_block   (push_block)
    );

    hcb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_block (push_block),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    hcb_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .key         (key_reg),
        .head_valid  (head_valid),
        .head        (head),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .cipher_char (cipher_char),
        .last_of_run (last_of_run)
    );

endmodule

/* rtl/hcb_checker.sv */
`timescale 1ns / 1ps

module hcb_checker
    import hcb_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  out_valid,
    input logic                  out_stall,
    input logic [CHAR_W-1:0]     cipher_char,
    input logic                  last_of_run
);

    localparam logic [CHAR_W-1:0] LETTER_Z = LETTER_A + CHAR_W'(ALPHA - 1);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(cipher_char) && $stable(last_of_run))
        else $error("stalled item changed");

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("item shown right after reset");

    a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (cipher_char >= LETTER_A) && (cipher_char <= LETTER_Z))
        else $error("cipher letter out of range");

    a_idle_no_out: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid && $past(!out_valid) && $past(!in_valid, 1) && $past(!in_valid, 2)
        && $past(!in_valid, 3) && $past(!in_valid, 4) && $past(!out_valid, 2)
        && $past(!out_valid, 3) && $past(!out_valid, 4) && $past(rst_n, 4) |=> !out_valid)
        else $error("item out of an idle block");

endmodule

bind hill_cipher_block_encrypt hcb_checker u_hcb_checker (.*);

/* bench/hill_cipher_block_encrypt_tb.sv */
`timescale 1ns / 1ps

module hill_cipher_block_encrypt_tb
    import hcb_pkg::*;
;

    localparam int KEY_ROWS     = 3;
    localparam int SETTLE_LAT   = 8;
    localparam int CYCLE_LIMIT  = 60000;
    localparam int RAND_PHASES  = 6;
    localparam int PHASE_ITEMS  = 14;

    typedef struct {
        logic [LETTER_W-1:0] letter;
        logic                last;
    } plain_item_t;

    typedef struct {
        logic [CHAR_W-1:0] code;
        logic              last;
    } cipher_item_t;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  in_valid     = 1'b0;
    logic                  in_stall;
    logic [LETTER_W-1:0]   letter_index = '0;
    logic                  message_end  = 1'b0;
    logic                  out_valid;
    logic                  out_stall    = 1'b0;
    logic [CHAR_W-1:0]     cipher_char;
    logic                  last_of_run;
    logic                  cfg_write    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;

    plain_item_t  pending_letters[$];
    cipher_item_t expected_chars[$];
    plain_item_t  next_letter;
    cipher_item_t want_char;

    // predictor state
    logic [1:0]            cfg_size;
    logic [KEY_ROW_W-1:0]  key_rows [KEY_ROWS];
    logic [LETTER_W-1:0]   held [KEY_ROWS];
    int                    held_count;

    int  errors = 0;
    int  cycles = 0;
    int  tx_wait;
    int  rx_wait;
    bit  tx_calm = 1'b0;
    bit  rx_calm = 1'b0;

    hill_cipher_block_encrypt u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .letter_index (letter_index),
        .message_end  (message_end),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .cipher_char  (cipher_char),
        .last_of_run  (last_of_run),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic void encipher(input logic [LETTER_W-1:0] letter, input logic last);
        int size;
        int pos;
        int n;
        int dim;
        int acc;
        int kv;
        int v;
        cipher_item_t res;
        size = (cfg_size < 2) ? 2 : int'(cfg_size);
        if (size > MAX_BLOCK)
        begin
            size = MAX_BLOCK;
        end
        if (size > KEY_ROWS)
        begin
            size = KEY_ROWS;
        end
        pos = held_count % KEY_ROWS;
        held[pos] = letter;
        n = pos + 1;
        if (n < size && !last)
        begin
            held_count = n;
            return;
        end
        dim = (n > size) ? n : size;
        for (int i = 0; i < n; i++)
        begin
            acc = 0;
            for (int j = 0; j < dim; j++)
            begin
                v = (j < n) ? int'(held[j]) : 0;
                kv = int'((key_rows[i] >> (LETTER_W * j)) & 31);
                acc = (acc + kv * v) % ALPHA;
            end
            res.code = CHAR_W'(acc + int'(LETTER_A));
            res.last = (i == n - 1);
            expected_chars.push_back(res);
        end
        for (int i = 0; i < KEY_ROWS; i++)
        begin
            held[i] = '0;
        end
        held_count = 0;
    endfunction

    function automatic logic [KEY_ROW_W-1:0] key_row(input int c0, input int c1, input int c2);
        return KEY_ROW_W'((c2 << (2 * LETTER_W)) | (c1 << LETTER_W) | c0);
    endfunction

    function automatic logic [KEY_ROW_W-1:0] rand_key_row();
        int mode;
        mode = $urandom_range(0, 9);
        if (mode == 0)
        begin
            return '0;
        end
        if (mode == 1)
        begin
            return '1;
        end
        if (mode == 2)
        begin
            return KEY_ROW_W'($urandom_range(0, 32767));
        end
        return key_row($urandom_range(0, 25), $urandom_range(0, 25), $urandom_range(0, 25));
    endfunction

    task automatic push_letter(input int letter, input bit last);
        plain_item_t it;
        it.letter = LETTER_W'(letter);
        it.last = last;
        pending_letters.push_back(it);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        while (pending_letters.size() != 0 || in_valid || expected_chars.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_LAT) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            CFG_BLOCK_SIZE: cfg_size = data[1:0];
            CFG_KEY_ROW0:   key_rows[0] = data;
            CFG_KEY_ROW1:   key_rows[1] = data;
            CFG_KEY_ROW2:   key_rows[2] = data;
            default: ;
        endcase
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic configure(input logic [1:0] size, input logic [KEY_ROW_W-1:0] r0,
                             input logic [KEY_ROW_W-1:0] r1, input logic [KEY_ROW_W-1:0] r2);
        wait_idle();
        write_reg(CFG_BLOCK_SIZE, CFG_DATA_W'(size));
        write_reg(CFG_KEY_ROW0, r0);
        write_reg(CFG_KEY_ROW1, r1);
        write_reg(CFG_KEY_ROW2, r2);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            letter_index <= '0;
            message_end <= 1'b0;
            tx_wait = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                encipher(letter_index, message_end);
            end
            if (!in_valid || !in_stall)
            begin
                if (tx_wait > 0)
                begin
                    tx_wait--;
                    in_valid <= 1'b0;
                end
                else if (pending_letters.size() != 0)
                begin
                    next_letter = pending_letters.pop_front();
                    letter_index <= next_letter.letter;
                    message_end <= next_letter.last;
                    in_valid <= 1'b1;
                    tx_wait = tx_calm ? 0 : $urandom_range(0, 5);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            rx_wait = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_chars.size() == 0)
                begin
                    $error("unexpected item: cipher_char %0d last_of_run %0d",
                           cipher_char, last_of_run);
                    errors++;
                end
                else
                begin
                    want_char = expected_chars.pop_front();
                    if (cipher_char !== want_char.code)
                    begin
                        $error("cipher_char expected %0d actual %0d", want_char.code, cipher_char);
                        errors++;
                    end
                    if (last_of_run !== want_char.last)
                    begin
                        $error("last_of_run expected %0d actual %0d", want_char.last, last_of_run);
                        errors++;
                    end
                end
                rx_wait = rx_calm ? 0 : $urandom_range(0, 5);
            end
            if (rx_wait > 0)
            begin
                out_stall <= 1'b1;
                rx_wait--;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        cfg_size = 2'd2;
        for (int i = 0; i < KEY_ROWS; i++)
        begin
            key_rows[i] = '0;
            held[i] = '0;
        end
        held_count = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // block of two, zeros, top letters, short and full message ends, raw letters
        configure(2'd2, key_row(3, 3, 0), key_row(2, 5, 0), '1);
        push_letter(0, 1'b0);
        push_letter(0, 1'b0);
        push_letter(25, 1'b0);
        push_letter(25, 1'b0);
        push_letter(7, 1'b1);
        push_letter(4, 1'b0);
        push_letter(7, 1'b1);
        push_letter(31, 1'b0);
        push_letter(26, 1'b0);

        // block of three with raw key entries
        tx_calm = 1'b1;
        rx_calm = 1'b1;
        configure(2'd3, '1, '1, '1);
        push_letter(31, 1'b0);
        push_letter(31, 1'b0);
        push_letter(31, 1'b0);
        push_letter(25, 1'b0);
        push_letter(1, 1'b1);
        push_letter(12, 1'b1);

        // sizes below two
        tx_calm = 1'b0;
        rx_calm = 1'b0;
        configure(2'd0, key_row(9, 4, 17), key_row(1, 25, 6), key_row(0, 0, 0));
        push_letter(3, 1'b0);
        push_letter(9, 1'b0);
        wait_idle();
        write_reg(CFG_BLOCK_SIZE, CFG_DATA_W'(2'd1));
        push_letter(17, 1'b0);
        push_letter(2, 1'b1);

        // lower the size with two letters held
        configure(2'd3, key_row(6, 24, 1), key_row(13, 16, 10), key_row(20, 17, 15));
        push_letter(5, 1'b0);
        push_letter(19, 1'b0);
        wait_idle();
        write_reg(CFG_BLOCK_SIZE, CFG_DATA_W'(2'd2));
        push_letter(11, 1'b0);

        // raise the size with one letter held
        push_letter(8, 1'b0);
        wait_idle();
        write_reg(CFG_BLOCK_SIZE, CFG_DATA_W'(2'd3));
        push_letter(1, 1'b0);
        push_letter(2, 1'b0);

        for (int p = 0; p < RAND_PHASES; p++)
        begin
            tx_calm = ($urandom_range(0, 2) == 0);
            rx_calm = ($urandom_range(0, 2) == 0);
            configure((p == 0) ? 2'd3 : (p == 1) ? 2'd2 : 2'($urandom_range(0, 3)),
                      rand_key_row(), rand_key_row(), rand_key_row());
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                push_letter(($urandom_range(0, 9) == 0) ? $urandom_range(26, 31)
                                                        : $urandom_range(0, 25),
                            ($urandom_range(0, 5) == 0));
            end
        end

        wait_idle();
        repeat (20) @(posedge clk);
        if (errors == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/hcb_pkg.sv
rtl/hcb_front.sv
rtl/hcb_queue.sv
rtl/hcb_back.sv
rtl/hill_cipher_block_encrypt.sv
rtl/hcb_checker.sv
bench/hill_cipher_block_encrypt_tb.sv
